[hdl/block_free_used_list_manager_core_defines.svh]
// Assertion macros for the block free/used list manager.
// Sampled on the rising edge of clock, disabled while reset is high.
`ifndef BLOCK_FREE_USED_LIST_MANAGER_CORE_DEFINES_SVH
`define BLOCK_FREE_USED_LIST_MANAGER_CORE_DEFINES_SVH

// expression holds at every edge
`define BFLM_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define BFLM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/bflm_pkg.sv]
// Shared types and constants for the block free/used list manager.
// No dependencies; imported by the controller, datapath and top level.
package bflm_pkg;

   localparam int NUM_BLOCKS_DEF = 256;
   localparam int IDX_W          = 8;
   localparam int CNT_W          = 9;
   localparam int REQ_TDATA_W    = 16;
   localparam int RSP_TDATA_W    = 40;
   localparam logic [CNT_W-1:0] BLOCKS_IN_USE_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_UNLINK           = 2'd0,
      OP_PUSH_FREE_HEAD   = 2'd1,
      OP_APPEND_FREE_TAIL = 2'd2,
      OP_PUSH_USED_HEAD   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_FAULT     = 2'd2,
      STATUS_UNLISTED  = 2'd3
   } status_type;

   typedef struct packed {
      logic [5:0]       pad;
      logic [IDX_W-1:0] block_index;
      opcode_type       opcode;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]       pad;
      logic             used_empty;
      logic [IDX_W-1:0] used_head;
      logic             free_empty;
      logic [IDX_W-1:0] free_head;
      logic [CNT_W-1:0] used_count;
      logic [CNT_W-1:0] free_count;
      status_type       status;
   } rsp_beat_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
      logic finish;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_busy;
   } dp_stat_type;

endpackage

[hdl/bflm_ctrl.sv]
// Controller state machine for the block free/used list manager.
// Depends on bflm_pkg; drives the datapath command struct.
module bflm_ctrl
   import bflm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_EXEC   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            if (!stat.rsp_busy) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/bflm_dp.sv]
// Datapath for the block free/used list manager: link and flag memories,
// list registers, bound register and response register. Depends on bflm_pkg.
`include "block_free_used_list_manager_core_defines.svh"
module bflm_dp
   import bflm_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_stat_type            stat,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [CNT_W-1:0]       csr_wr_data
);

   localparam int IW  = $clog2(NUM_BLOCKS);
   localparam int LW  = IW + 1;
   localparam int CW  = $clog2(NUM_BLOCKS + 1);
   localparam int XW  = (IW > IDX_W) ? IW : IDX_W;
   localparam int CXW = (CW > CNT_W) ? CW : CNT_W;

   typedef logic [LW-1:0] link_type;
   localparam link_type LINK_NULL = {1'b1, {IW{1'b0}}};

   link_type   next_mem [NUM_BLOCKS];
   link_type   prev_mem [NUM_BLOCKS];
   logic [1:0] flag_mem [NUM_BLOCKS];

   link_type   next_rd_ff, prev_rd_ff;
   logic [1:0] flag_rd_ff;

   opcode_type     op_ff;
   logic [IW-1:0]  idx_ff;
   logic           bad_ff;
   status_type     status_ff, status_in;
   logic           clear_b_ff, clear_b_in;
   link_type       free_first_ff, free_first_in, free_last_ff, free_last_in;
   link_type       used_first_ff, used_first_in, used_last_ff, used_last_in;
   logic [CW-1:0]  free_total_ff, free_total_in, used_total_ff, used_total_in;
   logic [CNT_W-1:0] biu_ff;
   logic [IW-1:0]  clr_cnt_ff;
   logic           rsp_valid_ff;
   rsp_beat_type   rsp_data_ff;

   req_beat_type   req_beat;
   logic [XW-1:0]  req_idx_x;
   logic [IW-1:0]  raddr;
   logic           req_bad;

   logic           nw_en, pw_en, fw_en;
   logic [IW-1:0]  nw_addr, pw_addr;
   link_type       nw_data, pw_data;
   logic [1:0]     fw_data;
   logic           next_we, prev_we, flag_we;
   logic [IW-1:0]  next_wa, prev_wa, flag_wa;
   link_type       next_wd, prev_wd;
   logic [1:0]     flag_wd;

   logic           on_free, on_used, push_ok;
   link_type       b_link;
   logic [XW-1:0]  ffx, ufx;
   logic [CXW-1:0] fcx, ucx;

   assign req_beat  = req_beat_type'(req_tdata);
   assign req_idx_x = XW'(req_beat.block_index);
   assign raddr     = req_idx_x[IW-1:0];
   assign req_bad   = (int'(req_beat.block_index) >= int'(biu_ff)) ||
                      (int'(req_beat.block_index) >= NUM_BLOCKS);

   assign on_free = flag_rd_ff[1];
   assign on_used = flag_rd_ff[0];
   assign b_link  = {1'b0, idx_ff};
   assign push_ok = next_rd_ff[IW] && prev_rd_ff[IW] && !on_free && !on_used;

   always_comb begin
      status_in     = STATUS_OK;
      clear_b_in    = 1'b0;
      free_first_in = free_first_ff;
      free_last_in  = free_last_ff;
      used_first_in = used_first_ff;
      used_last_in  = used_last_ff;
      free_total_in = free_total_ff;
      used_total_in = used_total_ff;
      nw_en   = 1'b0;
      nw_addr = idx_ff;
      nw_data = LINK_NULL;
      pw_en   = 1'b0;
      pw_addr = idx_ff;
      pw_data = LINK_NULL;
      fw_en   = 1'b0;
      fw_data = 2'b00;
      if (bad_ff) begin
         status_in = STATUS_BAD_INDEX;
      end else begin
         unique case (op_ff)
            OP_UNLINK: begin
               priority if (on_free && on_used) begin
                  status_in = STATUS_FAULT;
               end else if (!on_free && !on_used) begin
                  status_in = STATUS_UNLISTED;
               end else if (on_free && (free_total_ff == '0)) begin
                  status_in = STATUS_FAULT;
               end else if (on_used && (used_total_ff == '0)) begin
                  status_in = STATUS_FAULT;
               end else begin
                  if (prev_rd_ff[IW]) begin
                     if (on_free) begin
                        free_first_in = next_rd_ff;
                     end else begin
                        used_first_in = next_rd_ff;
                     end
                  end else begin
                     nw_en   = 1'b1;
                     nw_addr = prev_rd_ff[IW-1:0];
                     nw_data = next_rd_ff;
                  end
                  if (next_rd_ff[IW]) begin
                     if (on_free) begin
                        free_last_in = prev_rd_ff;
                     end else begin
                        used_last_in = prev_rd_ff;
                     end
                  end else begin
                     pw_en   = 1'b1;
                     pw_addr = next_rd_ff[IW-1:0];
                     pw_data = prev_rd_ff;
                  end
                  if (on_free) begin
                     free_total_in = free_total_ff - 1'b1;
                  end else begin
                     used_total_in = used_total_ff - 1'b1;
                  end
                  fw_en      = 1'b1;
                  fw_data    = 2'b00;
                  clear_b_in = 1'b1;
               end
            end
            OP_PUSH_FREE_HEAD: begin
               if (!push_ok) begin
                  status_in = STATUS_FAULT;
               end else begin
                  if (free_first_ff[IW]) begin
                     free_last_in = b_link;
                  end else begin
                     pw_en   = 1'b1;
                     pw_addr = free_first_ff[IW-1:0];
                     pw_data = b_link;
                     nw_en   = 1'b1;
                     nw_data = free_first_ff;
                  end
                  free_first_in = b_link;
                  free_total_in = free_total_ff + 1'b1;
                  fw_en   = 1'b1;
                  fw_data = 2'b10;
               end
            end
            OP_APPEND_FREE_TAIL: begin
               if (!push_ok) begin
                  status_in = STATUS_FAULT;
               end else begin
                  if (free_last_ff[IW]) begin
                     free_first_in = b_link;
                  end else begin
                     nw_en   = 1'b1;
                     nw_addr = free_last_ff[IW-1:0];
                     nw_data = b_link;
                     pw_en   = 1'b1;
                     pw_data = free_last_ff;
                  end
                  free_last_in  = b_link;
                  free_total_in = free_total_ff + 1'b1;
                  fw_en   = 1'b1;
                  fw_data = 2'b10;
               end
            end
            OP_PUSH_USED_HEAD: begin
               if (!push_ok) begin
                  status_in = STATUS_FAULT;
               end else begin
                  if (used_first_ff[IW]) begin
                     used_last_in = b_link;
                  end else begin
                     pw_en   = 1'b1;
                     pw_addr = used_first_ff[IW-1:0];
                     pw_data = b_link;
                     nw_en   = 1'b1;
                     nw_data = used_first_ff;
                  end
                  used_first_in = b_link;
                  used_total_in = used_total_ff + 1'b1;
                  fw_en   = 1'b1;
                  fw_data = 2'b01;
               end
            end
            default: begin
               status_in = STATUS_FAULT;
            end
         endcase
      end
   end

   // write port select: clearing pass, update, then clearing of the unlinked block
   always_comb begin
      next_we = 1'b0;
      next_wa = idx_ff;
      next_wd = LINK_NULL;
      prev_we = 1'b0;
      prev_wa = idx_ff;
      prev_wd = LINK_NULL;
      flag_we = 1'b0;
      flag_wa = idx_ff;
      flag_wd = 2'b00;
      priority if (cmd.clear) begin
         next_we = 1'b1;
         next_wa = clr_cnt_ff;
         prev_we = 1'b1;
         prev_wa = clr_cnt_ff;
         flag_we = 1'b1;
         flag_wa = clr_cnt_ff;
      end else if (cmd.exec) begin
         next_we = nw_en;
         next_wa = nw_addr;
         next_wd = nw_data;
         prev_we = pw_en;
         prev_wa = pw_addr;
         prev_wd = pw_data;
         flag_we = fw_en;
         flag_wd = fw_data;
      end else if (cmd.finish) begin
         next_we = clear_b_ff;
         prev_we = clear_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      if (cmd.accept) begin
         next_rd_ff <= next_mem[raddr];
         prev_rd_ff <= prev_mem[raddr];
         flag_rd_ff <= flag_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_beat.opcode;
         idx_ff <= raddr;
         bad_ff <= req_bad;
      end
      if (cmd.exec) begin
         status_ff  <= status_in;
         clear_b_ff <= clear_b_in;
      end
   end

   assign ffx = XW'(free_first_ff[IW-1:0]);
   assign ufx = XW'(used_first_ff[IW-1:0]);
   assign fcx = CXW'(free_total_ff);
   assign ucx = CXW'(used_total_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff.pad        <= '0;
         rsp_data_ff.status     <= status_ff;
         rsp_data_ff.free_count <= fcx[CNT_W-1:0];
         rsp_data_ff.used_count <= ucx[CNT_W-1:0];
         rsp_data_ff.free_head  <= free_first_ff[IW] ? '0 : ffx[IDX_W-1:0];
         rsp_data_ff.free_empty <= free_first_ff[IW];
         rsp_data_ff.used_head  <= used_first_ff[IW] ? '0 : ufx[IDX_W-1:0];
         rsp_data_ff.used_empty <= used_first_ff[IW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_first_ff <= LINK_NULL;
         free_last_ff  <= LINK_NULL;
         used_first_ff <= LINK_NULL;
         used_last_ff  <= LINK_NULL;
         free_total_ff <= '0;
         used_total_ff <= '0;
         biu_ff        <= BLOCKS_IN_USE_RESET;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.exec) begin
            free_first_ff <= free_first_in;
            free_last_ff  <= free_last_in;
            used_first_ff <= used_first_in;
            used_last_ff  <= used_last_in;
            free_total_ff <= free_total_in;
            used_total_ff <= used_total_in;
         end
         if (csr_wr_en) begin
            biu_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.clear_last = (clr_cnt_ff == IW'(NUM_BLOCKS - 1));
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = RSP_TDATA_W'(rsp_data_ff);

   `BFLM_ASSERT_ALWAYS(a_free_empty_count, free_first_ff[IW] == (free_total_ff == '0), "free head and count disagree")
   `BFLM_ASSERT_ALWAYS(a_used_empty_count, used_first_ff[IW] == (used_total_ff == '0), "used head and count disagree")
   `BFLM_ASSERT_ALWAYS(a_total_bound, (int'(free_total_ff) + int'(used_total_ff)) <= NUM_BLOCKS, "list counts exceed block count")
   `BFLM_ASSERT_NEXT(a_bad_no_change, cmd.exec && bad_ff, $stable(free_total_ff) && $stable(used_total_ff), "rejected index changed a count")

endmodule

[hdl/block_free_used_list_manager_core.sv]
// Channel   Ports                        Beat contents
// request   req_tvalid/tready/tdata      opcode, block_index
// response  rsp_tvalid/tready/tdata      status, counts, heads, empty flags
// config    csr_wr_en/csr_wr_data        blocks_in_use
//
// Each request passes through link and flag memory read, list update with
// neighbor writes, then clearing of the unlinked block's links with response load.
// After reset a clearing pass nulls every entry; req_tready stays low during
// it. A full response register holds the update in its last step until
// rsp_tready frees it. Depends on bflm_pkg, bflm_ctrl and bflm_dp.
module block_free_used_list_manager_core
   import bflm_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [1:0] opcode, [9:2] block_index, [15:10] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] status, [10:2] free_count, [19:11] used_count, [27:20] free_head,
   // [28] free_empty, [36:29] used_head, [37] used_empty, [39:38] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [CNT_W-1:0]       csr_wr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bflm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bflm_dp #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

[test/block_free_used_list_manager_core_test.sv]
// Self-checking testbench for block_free_used_list_manager_core: directed table, then
// random list traffic over several block limits, checked against an in-bench list model.
// Depends on bflm_pkg and the RTL of the core only.
module block_free_used_list_manager_core_test;
   import bflm_pkg::*;

   localparam logic [CNT_W-1:0] LINK_NULL = 9'h100;
   localparam int RANDOM_ITEMS = 275;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [CNT_W-1:0] limit;
      opcode_type       op;
      logic [IDX_W-1:0] idx;
      status_type       status;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en;
   logic [CNT_W-1:0]       csr_wr_data;

   logic [CNT_W-1:0] next_of [NUM_BLOCKS_DEF];
   logic [CNT_W-1:0] prev_of [NUM_BLOCKS_DEF];
   bit               in_free [NUM_BLOCKS_DEF];
   bit               in_used [NUM_BLOCKS_DEF];
   logic [CNT_W-1:0] free_first, free_last, used_first, used_last;
   logic [CNT_W-1:0] free_total, used_total;
   logic [CNT_W-1:0] blocks_limit;

   rsp_beat_type expected_snapshots[$];
   rsp_beat_type snap, got;
   req_beat_type req_seen;
   dir_row_type  dir_rows[$];
   int           mismatch_count;
   bit           req_beat_seen;
   bit           status_typed;
   status_type   typed_status;
   bit           hold_request;
   int           tx_idle_pct;
   int           rx_idle_pct;

   block_free_used_list_manager_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [CNT_W-1:0] as_link(logic [CNT_W-1:0] v);
      return v[8] ? LINK_NULL : v;
   endfunction

   function automatic status_type unlink_block(logic [IDX_W-1:0] b);
      logic [CNT_W-1:0] nx, pv;
      bit f, u;
      nx = as_link(next_of[b]);
      pv = as_link(prev_of[b]);
      f = in_free[b];
      u = in_used[b];
      if (f && u) return STATUS_FAULT;
      if (!f && !u) return STATUS_UNLISTED;
      if ((f && free_total == 0) || (u && used_total == 0)) return STATUS_FAULT;
      if (pv[8]) begin
         if (f) free_first = nx;
         else used_first = nx;
      end else begin
         next_of[pv[7:0]] = nx;
      end
      if (nx[8]) begin
         if (f) free_last = pv;
         else used_last = pv;
      end else begin
         prev_of[nx[7:0]] = pv;
      end
      if (f) free_total--;
      else used_total--;
      next_of[b] = LINK_NULL;
      prev_of[b] = LINK_NULL;
      in_free[b] = 1'b0;
      in_used[b] = 1'b0;
      return STATUS_OK;
   endfunction

   // update the list model for one request and return the snapshot it answers with
   function automatic rsp_beat_type apply_request(opcode_type op, logic [IDX_W-1:0] b);
      rsp_beat_type r;
      status_type   st;
      if ({1'b0, b} >= blocks_limit) begin
         st = STATUS_BAD_INDEX;
      end else if (op == OP_UNLINK) begin
         st = unlink_block(b);
      end else if (!next_of[b][8] || !prev_of[b][8] || in_free[b] || in_used[b]) begin
         st = STATUS_FAULT;
      end else begin
         st = STATUS_OK;
         case (op)
            OP_PUSH_FREE_HEAD: begin
               if (free_first[8]) free_last = {1'b0, b};
               else begin
                  prev_of[free_first[7:0]] = {1'b0, b};
                  next_of[b] = free_first;
               end
               free_first = {1'b0, b};
               free_total++;
               in_free[b] = 1'b1;
            end
            OP_APPEND_FREE_TAIL: begin
               if (free_last[8]) free_first = {1'b0, b};
               else begin
                  next_of[free_last[7:0]] = {1'b0, b};
                  prev_of[b] = free_last;
               end
               free_last = {1'b0, b};
               free_total++;
               in_free[b] = 1'b1;
            end
            default: begin
               if (used_first[8]) used_last = {1'b0, b};
               else begin
                  prev_of[used_first[7:0]] = {1'b0, b};
                  next_of[b] = used_first;
               end
               used_first = {1'b0, b};
               used_total++;
               in_used[b] = 1'b1;
            end
         endcase
      end
      r = '0;
      r.status     = st;
      r.free_count = free_total;
      r.used_count = used_total;
      r.free_head  = free_first[8] ? '0 : free_first[7:0];
      r.free_empty = free_first[8];
      r.used_head  = used_first[8] ? '0 : used_first[7:0];
      r.used_empty = used_first[8];
      return r;
   endfunction

   task automatic compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, seen);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         req_beat_seen = req_tvalid && req_tready;
         if (csr_wr_en) blocks_limit = csr_wr_data;
         if (req_tvalid && req_tready) begin
            req_seen = req_beat_type'(req_tdata);
            snap = apply_request(req_seen.opcode, req_seen.block_index);
            if (status_typed) snap.status = typed_status;
            expected_snapshots.push_back(snap);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_beat_type'(rsp_tdata);
            if (expected_snapshots.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response beat with none pending: %h", $realtime, rsp_tdata);
            end else begin
               snap = expected_snapshots.pop_front();
               compare_field("status", snap.status, got.status);
               compare_field("free_count", snap.free_count, got.free_count);
               compare_field("used_count", snap.used_count, got.used_count);
               compare_field("free_head", snap.free_head, got.free_head);
               compare_field("free_empty", snap.free_empty, got.free_empty);
               compare_field("used_head", snap.used_head, got.used_head);
               compare_field("used_empty", snap.used_empty, got.used_empty);
            end
         end
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic offer(opcode_type op, logic [IDX_W-1:0] idx, bit typed, status_type st);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      status_typed = typed;
      typed_status = st;
      req_tdata  <= req_beat_type'{6'd0, idx, op};
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_beat_seen);
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_snapshots.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(logic [CNT_W-1:0] value);
      drain_results();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // bias toward pushes of unlisted blocks and unlinks of listed ones
   task automatic random_request;
      int unsigned      pick;
      int unsigned      top;
      logic [IDX_W-1:0] idx;
      opcode_type       op;
      pick = $urandom_range(99);
      top  = 32'(blocks_limit) - 1;
      idx  = IDX_W'($urandom_range(top));
      if (pick < 45) begin
         op = opcode_type'($urandom_range(3, 1));
         for (int k = 0; k < 6 && (in_free[idx] || in_used[idx]); k++)
            idx = IDX_W'($urandom_range(top));
      end else if (pick < 85) begin
         op = OP_UNLINK;
         for (int k = 0; k < 6 && !(in_free[idx] || in_used[idx]); k++)
            idx = IDX_W'($urandom_range(top));
      end else begin
         op  = opcode_type'($urandom_range(3));
         idx = IDX_W'($urandom_range(255));
      end
      offer(op, idx, 1'b0, STATUS_OK);
   endtask

   initial begin
      logic [CNT_W-1:0] phase_limit [6];
      for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
         next_of[i] = LINK_NULL;
         prev_of[i] = LINK_NULL;
         in_free[i] = 1'b0;
         in_used[i] = 1'b0;
      end
      free_first = LINK_NULL;
      free_last  = LINK_NULL;
      used_first = LINK_NULL;
      used_last  = LINK_NULL;
      free_total = '0;
      used_total = '0;
      blocks_limit   = BLOCKS_IN_USE_RESET;
      mismatch_count = 0;
      req_beat_seen  = 1'b0;
      status_typed   = 1'b0;
      typed_status   = STATUS_OK;
      hold_request   = 1'b0;
      tx_idle_pct    = 10;
      rx_idle_pct    = 71;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      reset          = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      dir_rows = '{
         '{9'd0,   OP_UNLINK,           8'd0,   STATUS_UNLISTED},
         '{9'd0,   OP_PUSH_FREE_HEAD,   8'd0,   STATUS_OK},
         '{9'd0,   OP_PUSH_FREE_HEAD,   8'd0,   STATUS_FAULT},
         '{9'd0,   OP_APPEND_FREE_TAIL, 8'd255, STATUS_OK},
         '{9'd0,   OP_PUSH_USED_HEAD,   8'd128, STATUS_OK},
         '{9'd0,   OP_PUSH_USED_HEAD,   8'd255, STATUS_FAULT},
         '{9'd0,   OP_APPEND_FREE_TAIL, 8'd7,   STATUS_OK},
         '{9'd0,   OP_PUSH_FREE_HEAD,   8'd1,   STATUS_OK},
         '{9'd0,   OP_UNLINK,           8'd255, STATUS_OK},
         '{9'd0,   OP_UNLINK,           8'd1,   STATUS_OK},
         '{9'd0,   OP_UNLINK,           8'd7,   STATUS_OK},
         '{9'd0,   OP_UNLINK,           8'd0,   STATUS_OK},
         '{9'd0,   OP_UNLINK,           8'd0,   STATUS_UNLISTED},
         '{9'd0,   OP_PUSH_USED_HEAD,   8'd64,  STATUS_OK},
         '{9'd0,   OP_APPEND_FREE_TAIL, 8'd64,  STATUS_FAULT},
         '{9'd0,   OP_UNLINK,           8'd128, STATUS_OK},
         '{9'd0,   OP_UNLINK,           8'd64,  STATUS_OK},
         '{9'd1,   OP_PUSH_FREE_HEAD,   8'd1,   STATUS_BAD_INDEX},
         '{9'd0,   OP_PUSH_USED_HEAD,   8'd0,   STATUS_OK},
         '{9'd0,   OP_UNLINK,           8'd255, STATUS_BAD_INDEX},
         '{9'd256, OP_APPEND_FREE_TAIL, 8'd255, STATUS_OK},
         '{9'd0,   OP_UNLINK,           8'd255, STATUS_OK},
         '{9'd0,   OP_UNLINK,           8'd0,   STATUS_OK}
      };
      foreach (dir_rows[i]) begin
         if (dir_rows[i].limit != 0) write_limit(dir_rows[i].limit);
         offer(dir_rows[i].op, dir_rows[i].idx, 1'b1, dir_rows[i].status);
      end

      phase_limit = '{9'd256, 9'd1, 9'd2, 9'($urandom_range(255, 3)), 9'd16, 9'd256};
      for (int p = 0; p < 6; p++) begin
         write_limit(phase_limit[p]);
         tx_idle_pct = (p < 2) ? 10 : (p < 4) ? 71 : 0;
         rx_idle_pct = (p < 2) ? 71 : (p < 4) ? 10 : 0;
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (p == 0 && n == 60) hold_request = 1'b1;
            if (p == 3 && n == 100) drain_results();
            random_request();
         end
      end

      drain_results();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && expected_snapshots.size() == 0) begin
         $display("block_free_used_list_manager_core_test passed");
      end else begin
         $display("block_free_used_list_manager_core_test failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("block_free_used_list_manager_core_test failed");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/bflm_pkg.sv
hdl/bflm_ctrl.sv
hdl/bflm_dp.sv
hdl/block_free_used_list_manager_core.sv
test/block_free_used_list_manager_core_test.sv
